// ----- sv/tgarle_pkg.sv -----
// Shared types and constants for the run-length TGA pixel decoder.
package tgarle_pkg;

  // Decoder modes
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_RAW    = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FOUR_BYTE    = 2'd2;

  // Run bias of a packet header
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // One decoded color word
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] start_index;
    logic [7:0]  repeat_count;
    logic        overflow_error;
    logic        image_done;
  } tgarle_result_t;

endpackage

// ----- sv/tgarle_step.sv -----
// Decode state and per-byte next-state logic of the run-length TGA decoder.
module tgarle_step
  import tgarle_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [7:0]     step_byte,
  input  logic           step_new_image,
  input  logic [31:0]    total_pixels,
  input  logic           four_byte,
  output logic           res_valid,
  output tgarle_result_t res
);

  logic [1:0]  mode_r, mode_nxt, mode_e;
  logic [7:0]  left_r, left_nxt, left_e;
  logic [1:0]  pos_r, pos_nxt, pos_e;
  logic [31:0] pw_r, pw_nxt, pw_e;
  logic        halt_r, halt_nxt, halt_e;
  logic [7:0]  pc_r [4];
  logic [7:0]  pc_nxt [4];
  logic [7:0]  col [4];
  logic [7:0]  repeat_cnt;
  logic [32:0] end_sum;
  logic [2:0]  bpp;
  logic        overflow;
  logic        done;

  // Apply new-image clear, then decode one byte
  always_comb begin
    mode_e = step_new_image ? MODE_HEADER : mode_r;
    left_e = step_new_image ? 8'd0 : left_r;
    pos_e  = step_new_image ? 2'd0 : pos_r;
    pw_e   = step_new_image ? 32'd0 : pw_r;
    halt_e = step_new_image ? 1'b0 : halt_r;

    bpp        = four_byte ? 3'd4 : 3'd3;
    repeat_cnt = (mode_e == MODE_RUN) ? left_e : 8'd1;
    end_sum    = {1'b0, pw_e} + {25'd0, repeat_cnt};

    for (int i = 0; i < 4; i++) begin
      col[i]    = (pos_e == 2'(i)) ? step_byte : pc_r[i];
      pc_nxt[i] = pc_r[i];
    end

    mode_nxt  = mode_e;
    left_nxt  = left_e;
    pos_nxt   = pos_e;
    pw_nxt    = pw_e;
    halt_nxt  = halt_e;
    res_valid = 1'b0;
    overflow  = 1'b0;
    done      = 1'b0;

    if (!halt_e) begin
      if (mode_e != MODE_RAW && mode_e != MODE_RUN) begin
        // Packet header, dropped once the image is full
        if (pw_e < total_pixels) begin
          if (!step_byte[7]) begin
            mode_nxt = MODE_RAW;
            left_nxt = step_byte + 8'd1;
          end else begin
            mode_nxt = MODE_RUN;
            left_nxt = step_byte - RUN_BIAS;
          end
          pos_nxt = 2'd0;
        end
      end else begin
        // Gather a color byte
        pc_nxt[pos_e] = step_byte;
        if ({1'b0, pos_e} + 3'd1 < bpp) begin
          pos_nxt = pos_e + 2'd1;
        end else begin
          pos_nxt   = 2'd0;
          res_valid = 1'b1;
          if (end_sum > {1'b0, total_pixels}) begin
            overflow = 1'b1;
            halt_nxt = 1'b1;
          end else begin
            pw_nxt = end_sum[31:0];
            done   = (end_sum == {1'b0, total_pixels});
            if (mode_e == MODE_RAW) begin
              left_nxt = left_e - 8'd1;
              if (left_e == 8'd1) begin
                mode_nxt = MODE_HEADER;
              end
            end else begin
              left_nxt = 8'd0;
              mode_nxt = MODE_HEADER;
            end
          end
        end
      end
    end

    res.red            = col[2];
    res.green          = col[1];
    res.blue           = col[0];
    res.alpha          = four_byte ? col[3] : 8'd0;
    res.start_index    = pw_e;
    res.repeat_count   = repeat_cnt;
    res.overflow_error = overflow;
    res.image_done     = done;
  end

  // Advance control state on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HEADER;
      left_r <= 8'd0;
      pos_r  <= 2'd0;
      pw_r   <= 32'd0;
      halt_r <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      pos_r  <= pos_nxt;
      pw_r   <= pw_nxt;
      halt_r <= halt_nxt;
    end
  end

  // Hold partial color bytes
  always_ff @(posedge clk) begin
    if (step_en) begin
      for (int i = 0; i < 4; i++) begin
        pc_r[i] <= pc_nxt[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_overflow_halts: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && res.overflow_error |=> halt_r)
    else $error("overflow word did not halt the decoder");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && halt_r && !step_new_image |-> !res_valid)
    else $error("halted decoder produced a word");

  a_pw_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && !res.overflow_error |=>
      pw_r == $past(res.start_index) + {24'd0, $past(res.repeat_count)})
    else $error("pixel count did not advance by the repeat count");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.overflow_error && res.image_done))
    else $error("word flagged both done and overflow");
`endif

endmodule

// ----- sv/tga_rle_pixel_decoder_top.sv -----
// Top level of the run-length TGA pixel decoder: config, input and output registers.
// A byte is held in the input register, decoded combinationally, and its word is loaded
// into the output register when the byte is consumed. Throughput: one byte per cycle while the output is not stalled.
// A stalled output holds its word; the input register keeps taking bytes as words drain.
// Reset (rst_n low, synchronous) clears decode state, sets width and height to 1
// and selects 3-byte pixels; color bytes are not cleared.
module tga_rle_pixel_decoder_top
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_new_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [31:0] out_start_index,
  output logic [7:0]  out_repeat_count,
  output logic        out_overflow_error,
  output logic        out_image_done
);

  logic [15:0]    width_r, height_r;
  logic           four_r;
  logic [31:0]    total_r, total_nxt;
  logic [15:0]    mul_a, mul_b;
  logic           ir_valid_r;
  logic [7:0]     ir_byte_r;
  logic           ir_new_r;
  logic           consume;
  logic           res_valid;
  tgarle_result_t res;
  logic           out_valid_r;
  tgarle_result_t out_r;

  // Pick the multiplier operands for the pixel total
  always_comb begin
    mul_a = width_r;
    mul_b = height_r;
    case (cfg_index)
      CFG_IMAGE_WIDTH:  mul_a = cfg_wdata;
      CFG_IMAGE_HEIGHT: mul_b = cfg_wdata;
      default: begin
      end
    endcase
    total_nxt = 32'(mul_a) * 32'(mul_b);
  end

  // Config registers and the registered pixel total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      four_r   <= 1'b0;
      total_r  <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata;
          total_r <= total_nxt;
        end
        CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata;
          total_r  <= total_nxt;
        end
        CFG_FOUR_BYTE: four_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Consume the held byte when the output register can take a word
  assign consume  = ir_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ir_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      ir_valid_r <= 1'b1;
    end else if (consume) begin
      ir_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte_r <= in_byte;
      ir_new_r  <= in_new_image;
    end
  end

  tgarle_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (consume),
    .step_byte      (ir_byte_r),
    .step_new_image (ir_new_r),
    .total_pixels   (total_r),
    .four_byte      (four_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Output register: load on consume, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red            = out_r.red;
  assign out_green          = out_r.green;
  assign out_blue           = out_r.blue;
  assign out_alpha          = out_r.alpha;
  assign out_start_index    = out_r.start_index;
  assign out_repeat_count   = out_r.repeat_count;
  assign out_overflow_error = out_r.overflow_error;
  assign out_image_done     = out_r.image_done;

endmodule

// ----- bench/tgarle_decode_checker.sv -----
// Checker for the TGA run-length decoder: predicts each color word and compares it.
module tgarle_decode_checker
  import tgarle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_new_image,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_red,
  input  logic [7:0]         out_green,
  input  logic [7:0]         out_blue,
  input  logic [7:0]         out_alpha,
  input  logic [31:0]        out_start_index,
  input  logic [7:0]         out_repeat_count,
  input  logic               out_overflow_error,
  input  logic               out_image_done,
  output int unsigned        fail_count,
  output int unsigned        pending,
  output int unsigned        words_checked,
  output int unsigned        overflow_words,
  output int unsigned        done_words
);

  // Register copies
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        quad;

  // Decode state
  logic [1:0]  mode;
  logic [7:0]  left;
  logic [1:0]  pos;
  logic [7:0]  color [4];
  logic [31:0] written;
  logic        halted;

  tgarle_result_t colors_due [$];
  int unsigned errs = 0;
  int unsigned n_checked = 0;
  int unsigned n_overflow = 0;
  int unsigned n_done = 0;

  // Advance the decode state by one byte; return 1 when a color word comes out
  function automatic bit next_color_word(input logic [7:0] b, input logic ni,
                                         output tgarle_result_t w);
    logic [63:0] total;
    logic [63:0] run_end;
    logic [7:0]  rpt;
    logic [2:0]  px_bytes;
    total = 64'(img_w) * 64'(img_h);
    px_bytes = quad ? 3'd4 : 3'd3;
    w = '0;
    if (ni) begin
      mode = MODE_HEADER;
      left = '0;
      pos = '0;
      written = '0;
      halted = 1'b0;
    end
    if (halted) return 1'b0;

    // Packet header: drop it once the image is full
    if (mode != MODE_RAW && mode != MODE_RUN) begin
      if (64'(written) >= total) return 1'b0;
      if (!b[7]) begin
        mode = MODE_RAW;
        left = b + 8'd1;
      end else begin
        mode = MODE_RUN;
        left = b - RUN_BIAS;
      end
      pos = '0;
      return 1'b0;
    end

    // Gather color bytes until the current pixel size is reached
    color[pos] = b;
    if (3'(pos) + 3'd1 < px_bytes) begin
      pos = pos + 2'd1;
      return 1'b0;
    end
    pos = '0;

    rpt = (mode == MODE_RUN) ? left : 8'd1;
    w.red = color[2];
    w.green = color[1];
    w.blue = color[0];
    w.alpha = quad ? color[3] : 8'd0;
    w.start_index = written;
    w.repeat_count = rpt;
    run_end = 64'(written) + 64'(rpt);
    if (run_end > total) begin
      w.overflow_error = 1'b1;
      halted = 1'b1;
      return 1'b1;
    end
    written = run_end[31:0];
    w.image_done = (run_end == total);
    if (mode == MODE_RAW) begin
      left = left - 8'd1;
      if (left == 8'd0) mode = MODE_HEADER;
    end else begin
      left = '0;
      mode = MODE_HEADER;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  // Track registers, predict on accepted bytes, compare accepted words
  always @(posedge clk) begin
    tgarle_result_t predicted;
    tgarle_result_t due;
    if (!rst_n) begin
      img_w = 16'd1;
      img_h = 16'd1;
      quad = 1'b0;
      mode = MODE_HEADER;
      left = '0;
      pos = '0;
      written = '0;
      halted = 1'b0;
      colors_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  img_w = cfg_wdata;
          CFG_IMAGE_HEIGHT: img_h = cfg_wdata;
          CFG_FOUR_BYTE:    quad = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (next_color_word(in_byte, in_new_image, predicted)) colors_due.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (colors_due.size() == 0) begin
          $error("color word with none expected: start_index %0d", out_start_index);
          errs++;
        end else begin
          due = colors_due.pop_front();
          check_field("red", 32'(due.red), 32'(out_red));
          check_field("green", 32'(due.green), 32'(out_green));
          check_field("blue", 32'(due.blue), 32'(out_blue));
          check_field("alpha", 32'(due.alpha), 32'(out_alpha));
          check_field("start_index", due.start_index, out_start_index);
          check_field("repeat_count", 32'(due.repeat_count), 32'(out_repeat_count));
          check_field("overflow_error", 32'(due.overflow_error), 32'(out_overflow_error));
          check_field("image_done", 32'(due.image_done), 32'(out_image_done));
          n_checked++;
          if (due.overflow_error) n_overflow++;
          if (due.image_done) n_done++;
        end
      end
    end
    fail_count <= errs;
    pending <= colors_due.size();
    words_checked <= n_checked;
    overflow_words <= n_overflow;
    done_words <= n_done;
  end

endmodule

// ----- bench/tga_rle_pixel_decoder_top_test.sv -----
// Testbench top for the TGA run-length decoder: clock, reset, stimulus and verdict.
module tga_rle_pixel_decoder_top_test;
  import tgarle_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_new_image = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [31:0] out_start_index;
  logic [7:0]  out_repeat_count;
  logic        out_overflow_error;
  logic        out_image_done;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned overflow_words;
  int unsigned done_words;

  // Stimulus state
  bit          calm = 1'b0;
  int unsigned hold_requests = 0;
  bit          quad_now = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned image_bytes = 0;
  int unsigned settings = 0;

  tga_rle_pixel_decoder_top i_dut (.*);

  tgarle_decode_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic ni);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_new_image <= ni;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Drop valid and wait until every predicted word has drained
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] w, input logic [15:0] h, input bit q);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_FOUR_BYTE;
    cfg_wdata <= {15'($urandom), q};
    @(posedge clk);
    cfg_we <= 1'b0;
    quad_now = q;
    settings++;
  endtask

  task automatic push_pixel();
    repeat (quad_now ? 4 : 3) push_byte(pick_byte(), 1'b0);
  endtask

  // Well-formed image with random packets; sometimes a packet overshoots the end
  task automatic push_image(input int unsigned total, input int max_pkts);
    int unsigned left;
    int unsigned cap;
    int unsigned cnt;
    int unsigned npx;
    int p;
    bit raw;
    bit first;
    left = total;
    first = 1'b1;
    for (p = 0; p < max_pkts; p++) begin
      // Stop once the byte budget is spent
      if (image_bytes >= 560) break;
      // Image full: this header is dropped by the block
      if (left == 0) begin
        push_byte(pick_byte(), first);
        image_bytes++;
        break;
      end
      cap = (left < 128) ? left : 128;
      if (left < 128 && $urandom_range(0, 9) == 0) cnt = left + $urandom_range(1, 128 - left);
      else if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, cap);
      else cnt = $urandom_range(1, (cap < 6) ? cap : 6);
      raw = $urandom_range(0, 1);
      push_byte(raw ? 8'(cnt - 1) : 8'(cnt + 127), first);
      first = 1'b0;
      npx = raw ? ((cnt < left + 1) ? cnt : left + 1) : 1;
      repeat (npx) push_pixel();
      image_bytes += 1 + npx * (quad_now ? 4 : 3);
      if (cnt > left) break;
      left -= cnt;
    end
  endtask

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    bit q;
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one 3-byte pixel fills the image, the next header is dropped
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h55, 1'b0);
    settle();

    // Longest run overflows a 2x2 image, then the block stays halted
    program_regs(16'd2, 16'd2, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h12, 1'b0);

    // Run of two, longest raw header, then shrink the pixel size mid-pixel
    push_byte(8'h81, 1'b1);
    repeat (4) push_byte(pick_byte(), 1'b0);
    push_byte(8'h7F, 1'b0);
    repeat (4) push_byte(pick_byte(), 1'b0);
    repeat (2) push_byte(pick_byte(), 1'b0);
    settle();
    program_regs(16'd2, 16'd2, 1'b0);
    push_byte(pick_byte(), 1'b0);
    settle();

    // Zero-size image: headers are dropped
    program_regs(16'd0, 16'd7, 1'b0);
    push_byte(8'h80, 1'b1);

    // Random settings, each followed by a few images
    phase = 0;
    while (image_bytes < 560) begin
      settle();
      calm = (image_bytes >= 460);
      case ($urandom_range(0, 9))
        0: begin w = 16'hFFFF; h = 16'hFFFF; end
        1: begin w = 16'd1; h = 16'd1; end
        2: begin
          w = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 9));
          h = (w == 0) ? 16'($urandom_range(0, 9)) : 16'd0;
        end
        3: begin w = 16'hFFFF; h = 16'($urandom_range(1, 3)); end
        default: begin w = 16'($urandom_range(1, 12)); h = 16'($urandom_range(1, 12)); end
      endcase
      q = $urandom_range(0, 1);
      if (phase == 0) begin
        w = 16'hFFFF;
        h = 16'hFFFF;
        q = 1'b1;
      end
      program_regs(w, h, q);
      if (phase == 0) hold_requests++;
      repeat ($urandom_range(1, 4)) begin
        // Noise: random bytes, now and then a new image in the middle
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(3, 10)) push_byte(pick_byte(), $urandom_range(0, 7) == 0);
        end
        push_image(32'(w) * 32'(h), (phase == 0) ? 12 : $urandom_range(1, 8));
      end
      phase++;
    end

    // Closing image with no idling on either side
    settle();
    calm = 1'b1;
    program_regs(16'd5, 16'd4, 1'b0);
    push_image(32'd20, 6);

    // Drain
    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && pending != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes over %0d register settings.", bytes_sent, settings);
    $display("Checked %0d color words: %0d overflow, %0d completing an image.",
             words_checked, overflow_words, done_words);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
